// ----- hdl/sprite_animation_frame_stepper_macros.svh -----
// assertion macros shared by the sprite animation frame stepper
`ifndef SPRITE_ANIMATION_FRAME_STEPPER_MACROS_SVH
`define SPRITE_ANIMATION_FRAME_STEPPER_MACROS_SVH

// same-cycle implication, disabled during reset
`define SAFS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define SAFS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hdl/safs_pkg.sv -----
// types and constants of the sprite animation frame stepper
package safs_pkg;

  // table geometry
  localparam int NUM_OBJECTS = 128;
  localparam int MAX_FRAMES  = 64;
  localparam int IDX_W       = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;

  // fixed field widths
  localparam int OBJ_W   = 7;
  localparam int TIME_W  = 32;
  localparam int SIZE_W  = 2;
  localparam int TILE_W  = 10;
  localparam int COUNT_W = 7;
  localparam int FRAME_W = 6;

  // tile address arithmetic
  localparam int TILE_STRIDE = 16;
  localparam int TILE_SHIFT  = $clog2(TILE_STRIDE);

  // action codes
  localparam logic ACT_ASSIGN = 1'b0;
  localparam logic ACT_UPDATE = 1'b1;

  typedef struct packed {
    logic               action;
    logic [OBJ_W-1:0]   obj_index;
    logic [TIME_W-1:0]  now;
    logic [SIZE_W-1:0]  size_code;
    logic [TILE_W-1:0]  base_tile;
    logic [COUNT_W-1:0] frame_count;
    logic [TIME_W-1:0]  speed;
  } in_item_t;

  typedef struct packed {
    logic [OBJ_W-1:0]  out_obj;
    logic              tile_written;
    logic [TILE_W-1:0] tile_out;
    logic [SIZE_W-1:0] size_out;
  } out_item_t;

  // one animation table entry
  typedef struct packed {
    logic [TIME_W-1:0]  deadline;
    logic [TIME_W-1:0]  tick_speed;
    logic [COUNT_W-1:0] frames_total;
    logic [FRAME_W-1:0] frame_now;
    logic [TILE_W-1:0]  first_tile;
    logic [SIZE_W-1:0]  size_store;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_cmd_t;

endpackage

// ----- hdl/safs_ram.sv -----
// generic single-port-write ram with registered read
module safs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/safs_ctrl.sv -----
// controller for the frame stepper: sequencing and handshakes
module safs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output safs_pkg::ctrl_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  // handshakes and commands
  assign in_stall    = (state_r != S_IDLE);
  assign out_free    = !out_valid_r || !out_stall;
  assign cmd.capture = in_valid && (state_r == S_IDLE);
  assign cmd.commit  = (state_r == S_EXEC) && out_free;
  assign out_valid   = out_valid_r;

  // next state
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.capture) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- hdl/safs_dp.sv -----
// datapath for the frame stepper: table, valid bits and result register
module safs_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  safs_pkg::ctrl_cmd_t cmd,
  input  safs_pkg::in_item_t  in_item,
  output safs_pkg::out_item_t out_item
);

  safs_pkg::in_item_t  item_r;
  safs_pkg::out_item_t res_r;
  safs_pkg::out_item_t res_nxt;
  safs_pkg::entry_t    ent;
  safs_pkg::entry_t    ent_nxt;

  logic [safs_pkg::ENTRY_W-1:0]  rd_data;
  logic [safs_pkg::NUM_OBJECTS-1:0] valid_r;
  logic [safs_pkg::IDX_W-1:0]    rd_addr;
  logic [safs_pkg::IDX_W-1:0]    addr;
  logic                          in_range;
  logic                          is_assign;
  logic                          hit;
  logic                          fire;
  logic                          we;
  logic [safs_pkg::TIME_W-1:0]   addend;
  logic [safs_pkg::TIME_W-1:0]   deadline_new;
  logic [safs_pkg::COUNT_W-1:0]  count_sat;
  logic [safs_pkg::COUNT_W-1:0]  frame_inc;
  logic [safs_pkg::FRAME_W-1:0]  frame_new;
  logic [safs_pkg::TILE_W-1:0]   tile_new;

  // table read on accept, write on commit of an assign or a fired update
  assign rd_addr = in_item.obj_index[safs_pkg::IDX_W-1:0];
  assign addr    = item_r.obj_index[safs_pkg::IDX_W-1:0];

  safs_ram #(
    .WIDTH(safs_pkg::ENTRY_W),
    .DEPTH(safs_pkg::NUM_OBJECTS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (addr),
    .wdata (ent_nxt),
    .re    (cmd.capture),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign ent = safs_pkg::entry_t'(rd_data);

  // decode of the held item
  assign in_range  = ({1'b0, item_r.obj_index} <
                      (safs_pkg::OBJ_W+1)'(safs_pkg::NUM_OBJECTS));
  assign is_assign = (item_r.action == safs_pkg::ACT_ASSIGN);
  assign hit       = in_range && valid_r[addr];
  assign fire      = !is_assign && hit && (item_r.now > ent.deadline);
  assign we        = cmd.commit && in_range && (is_assign || fire);

  // new deadline, one shared adder
  assign addend       = is_assign ? item_r.speed : ent.tick_speed;
  assign deadline_new = item_r.now + addend;

  // frame count clamp for assign
  always_comb begin
    count_sat = item_r.frame_count;
    if (item_r.frame_count == '0) begin
      count_sat = safs_pkg::COUNT_W'(1);
    end else if (item_r.frame_count > safs_pkg::COUNT_W'(safs_pkg::MAX_FRAMES)) begin
      count_sat = safs_pkg::COUNT_W'(safs_pkg::MAX_FRAMES);
    end
  end

  // frame advance with wrap, zero total acts as one
  assign frame_inc = {1'b0, ent.frame_now} + safs_pkg::COUNT_W'(1);
  assign frame_new = (frame_inc >= ent.frames_total) ? '0 :
                     frame_inc[safs_pkg::FRAME_W-1:0];
  assign tile_new  = ent.first_tile +
                     (safs_pkg::TILE_W'(frame_new) << safs_pkg::TILE_SHIFT);

  // entry to write back and result to report
  always_comb begin
    ent_nxt              = ent;
    res_nxt.out_obj      = item_r.obj_index;
    res_nxt.tile_written = 1'b0;
    res_nxt.tile_out     = '0;
    res_nxt.size_out     = '0;
    if (in_range && is_assign) begin
      ent_nxt.deadline     = deadline_new;
      ent_nxt.tick_speed   = item_r.speed;
      ent_nxt.frames_total = count_sat;
      ent_nxt.frame_now    = '0;
      ent_nxt.first_tile   = item_r.base_tile;
      ent_nxt.size_store   = item_r.size_code;
      res_nxt.tile_written = 1'b1;
      res_nxt.tile_out     = item_r.base_tile;
      res_nxt.size_out     = item_r.size_code;
    end else if (hit) begin
      res_nxt.size_out = ent.size_store;
      if (fire) begin
        ent_nxt.deadline     = deadline_new;
        ent_nxt.frame_now    = frame_new;
        res_nxt.tile_written = 1'b1;
        res_nxt.tile_out     = tile_new;
      end
    end
  end

  // item and result registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_item;
    end
    if (cmd.commit) begin
      res_r <= res_nxt;
    end
  end

  // per-entry valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.commit && in_range && is_assign) begin
      valid_r[addr] <= 1'b1;
    end
  end

  assign out_item = res_r;

endmodule

// ----- hdl/sprite_animation_frame_stepper.sv -----
// an accepted item and its table entry are registered for the execute step, where
//   its result is registered on commit; no new item is accepted before that, set by the
//   read then write of the single-write-port animation table for each item
// a stalled result holds the block in its execute step until it is taken
// reset: synchronous active-low; clears the per-object valid bits at once,
//   table contents stay undefined until assigned, no clearing pass
`include "sprite_animation_frame_stepper_macros.svh"

module sprite_animation_frame_stepper (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  safs_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output safs_pkg::out_item_t out_item
);

  safs_pkg::ctrl_cmd_t cmd;

  // sequencing
  safs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // table and result datapath
  safs_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .out_item (out_item)
  );

  // checks
  `SAFS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  `SAFS_ASSERT_NEXT(a_commit_shows_result, clk, rst_n, cmd.commit, out_valid)
  `SAFS_ASSERT_NEXT(a_commit_frees_input, clk, rst_n, cmd.commit, !in_stall)
  `SAFS_ASSERT_NOW(a_no_capture_on_commit, clk, rst_n, cmd.capture, !cmd.commit)

endmodule
